/* rtl/thermal_freq_throttle_core_defines.svh */
// ---------------------------------------------------------------------------
// Thermal frequency throttle - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef THERMAL_FREQ_THROTTLE_CORE_DEFINES_SVH
`define THERMAL_FREQ_THROTTLE_CORE_DEFINES_SVH

// Same-cycle implication
`define TFT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tft_pkg.sv */
// ---------------------------------------------------------------------------
// Thermal frequency throttle - package
// Widths, register indexes, level codes, scaling constants and shared types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tft_pkg;

    localparam int FREQ_W    = 23;
    localparam int SPAN_W    = FREQ_W + 1;
    localparam int TEMP_W    = 9;
    localparam int LIM_W     = 7;
    localparam int LEVEL_W   = 3;
    localparam int CFG_IDX_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HW_MIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HW_MAX       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_FLOOR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_CEILING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT   = 3'd4;

    // Throttle levels
    localparam logic [LEVEL_W-1:0] LVL_COOL     = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_LIGHT    = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_MEDIUM   = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_STRONG   = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_FAILSAFE = 3'd4;

    // Register reset values
    localparam int HW_MIN_RST_I = 800000;
    localparam int HW_MAX_RST_I = 3000000;
    localparam int LIM_RST_I    = 95;
    localparam logic [FREQ_W-1:0] HW_MIN_RST = FREQ_W'(HW_MIN_RST_I);
    localparam logic [FREQ_W-1:0] HW_MAX_RST = FREQ_W'(HW_MAX_RST_I);
    localparam logic [LIM_W-1:0]  LIM_RST    = LIM_W'(LIM_RST_I);

    // Reciprocals for percent of range: ceil(pct * 2^32 / 100), exact for 23-bit magnitudes
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] RECIP_85 = 32'd3650722202;
    localparam logic [RECIP_W-1:0] RECIP_65 = 32'd2791728743;
    localparam logic [RECIP_W-1:0] RECIP_40 = 32'd1717986919;
    localparam logic [RECIP_W-1:0] RECIP_10 = 32'd429496730;

    // Reciprocals for percent of temperature limit: ceil(pct * 2^16 / 100)
    localparam int THR_SHIFT = 16;
    localparam logic [THR_SHIFT-1:0] THR_79 = 16'd51774;
    localparam logic [THR_SHIFT-1:0] THR_86 = 16'd56361;
    localparam logic [THR_SHIFT-1:0] THR_93 = 16'd60949;

    // Derived values for the reset configuration
    localparam int RST_SPAN_I = HW_MAX_RST_I - HW_MIN_RST_I;
    localparam logic [FREQ_W-1:0] RST_F_L1 = FREQ_W'(HW_MIN_RST_I + (RST_SPAN_I * 85) / 100);
    localparam logic [FREQ_W-1:0] RST_F_L2 = FREQ_W'(HW_MIN_RST_I + (RST_SPAN_I * 65) / 100);
    localparam logic [FREQ_W-1:0] RST_F_L3 = FREQ_W'(HW_MIN_RST_I + (RST_SPAN_I * 40) / 100);
    localparam logic [SPAN_W-1:0] RST_BAND = SPAN_W'(RST_SPAN_I / 10);
    localparam logic [LIM_W-1:0]  RST_TH_L1 = LIM_W'((LIM_RST_I * 79) / 100);
    localparam logic [LIM_W-1:0]  RST_TH_L2 = LIM_W'((LIM_RST_I * 86) / 100);
    localparam logic [LIM_W-1:0]  RST_TH_L3 = LIM_W'((LIM_RST_I * 93) / 100);

    // Limits derived from configuration, handed to the evaluation logic
    typedef struct packed {
        logic [FREQ_W-1:0]        lo;
        logic [FREQ_W-1:0]        top;
        logic [FREQ_W-1:0]        f_l1;
        logic [FREQ_W-1:0]        f_l2;
        logic [FREQ_W-1:0]        f_l3;
        logic [FREQ_W-1:0]        floor_freq;
        logic [LIM_W-1:0]         lim;
        logic [LIM_W-1:0]         th_l1;
        logic [LIM_W-1:0]         th_l2;
        logic [LIM_W-1:0]         th_l3;
        logic signed [SPAN_W-1:0] band;
    } tft_limits_t;

endpackage

`default_nettype wire

/* rtl/tft_cfg.sv */
// ---------------------------------------------------------------------------
// Thermal frequency throttle - configuration registers
// Holds the five registers and registers the limits derived from them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tft_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [tft_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tft_pkg::FREQ_W-1:0]     cfg_data,
    output tft_pkg::tft_limits_t                limits
);
    import tft_pkg::*;

    localparam int PROD_W = FREQ_W + RECIP_W;
    localparam int TPROD_W = LIM_W + THR_SHIFT;

    logic [FREQ_W-1:0] hw_min_reg;
    logic [FREQ_W-1:0] hw_max_reg;
    logic [FREQ_W-1:0] safe_floor_reg;
    logic [FREQ_W-1:0] safe_ceiling_reg;
    logic [LIM_W-1:0]  temp_limit_reg;

    logic [FREQ_W-1:0]        top_next;
    logic signed [SPAN_W-1:0] span;
    logic                     span_neg;
    logic [SPAN_W-1:0]        span_abs;
    logic [FREQ_W-1:0]        mag;
    logic [PROD_W-1:0]        prod_85;
    logic [PROD_W-1:0]        prod_65;
    logic [PROD_W-1:0]        prod_40;
    logic [PROD_W-1:0]        prod_10;
    logic [TPROD_W-1:0]       tprod_79;
    logic [TPROD_W-1:0]       tprod_86;
    logic [TPROD_W-1:0]       tprod_93;
    logic [FREQ_W-1:0]        q_10;
    tft_limits_t              limits_next;
    tft_limits_t              limits_reg;

    // Add a signed share of the range to the minimum
    function automatic logic [FREQ_W-1:0] add_share(
        input logic [FREQ_W-1:0] base,
        input logic [FREQ_W-1:0] share,
        input logic              neg
    );
        logic [SPAN_W:0] ext;
        logic [SPAN_W:0] sum;
        ext = {2'b00, share};
        sum = neg ? ({2'b00, base} - ext) : ({2'b00, base} + ext);
        return sum[FREQ_W-1:0];
    endfunction

    // Write the configuration registers; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_min_reg       <= HW_MIN_RST;
            hw_max_reg       <= HW_MAX_RST;
            safe_floor_reg   <= '0;
            safe_ceiling_reg <= '0;
            temp_limit_reg   <= LIM_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_HW_MIN:       hw_min_reg       <= cfg_data;
                REG_HW_MAX:       hw_max_reg       <= cfg_data;
                REG_SAFE_FLOOR:   safe_floor_reg   <= cfg_data;
                REG_SAFE_CEILING: safe_ceiling_reg <= cfg_data;
                REG_TEMP_LIMIT:   temp_limit_reg   <= cfg_data[LIM_W-1:0];
                default:          ;
            endcase
        end
    end

    // Pick the effective ceiling and the signed range above the minimum
    always_comb
    begin
        if (safe_ceiling_reg != '0 && safe_ceiling_reg >= hw_min_reg
                && safe_ceiling_reg < hw_max_reg)
            top_next = safe_ceiling_reg;
        else
            top_next = hw_max_reg;
        span     = $signed({1'b0, top_next}) - $signed({1'b0, hw_min_reg});
        span_neg = span[SPAN_W-1];
        span_abs = span_neg ? (-span) : span;
        mag      = span_abs[FREQ_W-1:0];
    end

    // Scale by reciprocal multiplication, truncating the magnitude
    assign prod_85  = {{RECIP_W{1'b0}}, mag} * {{FREQ_W{1'b0}}, RECIP_85};
    assign prod_65  = {{RECIP_W{1'b0}}, mag} * {{FREQ_W{1'b0}}, RECIP_65};
    assign prod_40  = {{RECIP_W{1'b0}}, mag} * {{FREQ_W{1'b0}}, RECIP_40};
    assign prod_10  = {{RECIP_W{1'b0}}, mag} * {{FREQ_W{1'b0}}, RECIP_10};
    assign tprod_79 = {{THR_SHIFT{1'b0}}, temp_limit_reg} * {{LIM_W{1'b0}}, THR_79};
    assign tprod_86 = {{THR_SHIFT{1'b0}}, temp_limit_reg} * {{LIM_W{1'b0}}, THR_86};
    assign tprod_93 = {{THR_SHIFT{1'b0}}, temp_limit_reg} * {{LIM_W{1'b0}}, THR_93};
    assign q_10     = prod_10[PROD_W-1 -: FREQ_W];

    // Assemble the next set of limits
    always_comb
    begin
        limits_next.lo         = hw_min_reg;
        limits_next.top        = top_next;
        limits_next.f_l1       = add_share(hw_min_reg, prod_85[PROD_W-1 -: FREQ_W], span_neg);
        limits_next.f_l2       = add_share(hw_min_reg, prod_65[PROD_W-1 -: FREQ_W], span_neg);
        limits_next.f_l3       = add_share(hw_min_reg, prod_40[PROD_W-1 -: FREQ_W], span_neg);
        limits_next.floor_freq = safe_floor_reg;
        limits_next.lim        = temp_limit_reg;
        limits_next.th_l1      = tprod_79[TPROD_W-1 -: LIM_W];
        limits_next.th_l2      = tprod_86[TPROD_W-1 -: LIM_W];
        limits_next.th_l3      = tprod_93[TPROD_W-1 -: LIM_W];
        limits_next.band       = span_neg ? (-$signed({1'b0, q_10})) : $signed({1'b0, q_10});
    end

    // Hold the derived limits for the evaluation stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.lo         <= HW_MIN_RST;
            limits_reg.top        <= HW_MAX_RST;
            limits_reg.f_l1       <= RST_F_L1;
            limits_reg.f_l2       <= RST_F_L2;
            limits_reg.f_l3       <= RST_F_L3;
            limits_reg.floor_freq <= '0;
            limits_reg.lim        <= LIM_RST;
            limits_reg.th_l1      <= RST_TH_L1;
            limits_reg.th_l2      <= RST_TH_L2;
            limits_reg.th_l3      <= RST_TH_L3;
            limits_reg.band       <= RST_BAND;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    assign limits = limits_reg;

endmodule

`default_nettype wire

/* rtl/tft_eval.sv */
// ---------------------------------------------------------------------------
// Thermal frequency throttle - sample evaluation
// Selects the level and target, applies the floor and the hysteresis band.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tft_eval (
    input  wire tft_pkg::tft_limits_t           limits,
    input  wire logic [tft_pkg::TEMP_W-1:0]     temp,
    input  wire logic [tft_pkg::FREQ_W-1:0]     last_applied,
    output logic [tft_pkg::FREQ_W-1:0]          freq,
    output logic                                go,
    output logic [tft_pkg::LEVEL_W-1:0]         level
);
    import tft_pkg::*;

    logic signed [TEMP_W-1:0] temp_s;
    logic                     hot;
    logic                     ge_l1;
    logic                     ge_l2;
    logic                     ge_l3;
    logic [FREQ_W-1:0]        sel_freq;
    logic [FREQ_W-1:0]        diff;

    assign temp_s = $signed(temp);
    assign hot    = temp_s >= $signed({2'b00, limits.lim});
    assign ge_l3  = temp_s >= $signed({2'b00, limits.th_l3});
    assign ge_l2  = temp_s >= $signed({2'b00, limits.th_l2});
    assign ge_l1  = temp_s >= $signed({2'b00, limits.th_l1});

    // Pick the level by the highest threshold reached
    always_comb
    begin
        if (hot)
        begin
            sel_freq = limits.lo;
            level    = LVL_FAILSAFE;
        end
        else if (ge_l3)
        begin
            sel_freq = limits.f_l3;
            level    = LVL_STRONG;
        end
        else if (ge_l2)
        begin
            sel_freq = limits.f_l2;
            level    = LVL_MEDIUM;
        end
        else if (ge_l1)
        begin
            sel_freq = limits.f_l1;
            level    = LVL_LIGHT;
        end
        else
        begin
            sel_freq = limits.top;
            level    = LVL_COOL;
        end
    end

    // Raise to the floor unless failsafe
    always_comb
    begin
        if (limits.floor_freq != '0 && !hot && sel_freq < limits.floor_freq)
            freq = limits.floor_freq;
        else
            freq = sel_freq;
    end

    // Apply only when the change leaves the hysteresis band
    assign diff = (freq >= last_applied) ? (freq - last_applied) : (last_applied - freq);
    assign go   = $signed({2'b00, diff}) > $signed({limits.band[SPAN_W-1], limits.band});

endmodule

`default_nettype wire

/* rtl/thermal_freq_throttle_core.sv */
// ---------------------------------------------------------------------------
// Thermal frequency throttle - top level
// Maps one temperature sample to a frequency ceiling with hysteresis.
// ---------------------------------------------------------------------------
//  channel   signals                                     direction
//  temp      temp_valid/temp_ready, temp_c                in
//  result    result_valid/result_ready, target_freq,      out
//            apply, applied_freq, level
//  cfg       cfg_wr_en, cfg_index, cfg_data                in
//
//  A sample is registered on transfer and its result in the result stage;
//  one sample per cycle sustained while results are taken and no write is on.
//  Derived limits are registered from the configuration, so temp_ready is
//  low in a cycle with a configuration write.
//  A stalled result holds the sample stage; the input also stalls when both
//  stages are full. Asynchronous active-low reset clears all control state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thermal_freq_throttle_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [tft_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tft_pkg::FREQ_W-1:0]     cfg_data,
    input  wire logic                           temp_valid,
    output logic                                temp_ready,
    input  wire logic [tft_pkg::TEMP_W-1:0]     temp_c,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic [tft_pkg::FREQ_W-1:0]          target_freq,
    output logic                                apply,
    output logic [tft_pkg::FREQ_W-1:0]          applied_freq,
    output logic [tft_pkg::LEVEL_W-1:0]         level
);
    import tft_pkg::*;

    tft_limits_t        limits;
    logic               smp_valid_reg;
    logic [TEMP_W-1:0]  temp_reg;
    logic               res_valid_reg;
    logic [FREQ_W-1:0]  target_freq_reg;
    logic               apply_reg;
    logic [FREQ_W-1:0]  last_applied_reg;
    logic [FREQ_W-1:0]  last_applied_next;
    logic [LEVEL_W-1:0] level_reg;
    logic [FREQ_W-1:0]  eval_freq;
    logic               eval_go;
    logic [LEVEL_W-1:0] eval_level;
    logic               res_load;
    logic               smp_load;

    tft_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    tft_eval u_eval (
        .limits       (limits),
        .temp         (temp_reg),
        .last_applied (last_applied_reg),
        .freq         (eval_freq),
        .go           (eval_go),
        .level        (eval_level)
    );

    // Advance the result stage when it is empty or being taken
    assign res_load   = smp_valid_reg && (!res_valid_reg || result_ready);
    assign temp_ready = (!smp_valid_reg || res_load) && !cfg_wr_en;
    assign smp_load   = temp_valid && temp_ready;

    assign last_applied_next = eval_go ? eval_freq : last_applied_reg;

    // Sample stage: hold the temperature of the last transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            smp_valid_reg <= 1'b0;
        else if (smp_load)
            smp_valid_reg <= 1'b1;
        else if (res_load)
            smp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (smp_load)
            temp_reg <= temp_c;
    end

    // Result stage and applied-limit state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg    <= 1'b0;
            last_applied_reg <= '0;
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg    <= 1'b1;
                last_applied_reg <= last_applied_next;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            target_freq_reg <= eval_freq;
            apply_reg       <= eval_go;
            level_reg       <= eval_level;
        end
    end

    assign result_valid = res_valid_reg;
    assign target_freq  = target_freq_reg;
    assign apply        = apply_reg;
    assign applied_freq = last_applied_reg;
    assign level        = level_reg;

endmodule

`default_nettype wire

/* rtl/tft_checker.sv */
// ---------------------------------------------------------------------------
// Thermal frequency throttle - port checker
// Watches the top-level ports and is bound onto the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "thermal_freq_throttle_core_defines.svh"

module tft_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic                           temp_ready,
    input  wire logic                           result_valid,
    input  wire logic                           result_ready,
    input  wire logic [tft_pkg::FREQ_W-1:0]     target_freq,
    input  wire logic                           apply,
    input  wire logic [tft_pkg::FREQ_W-1:0]     applied_freq,
    input  wire logic [tft_pkg::LEVEL_W-1:0]    level
);
    import tft_pkg::*;

    // An applied limit is the target of the same result
    `TFT_ASSERT_NOW(a_apply_tracks, result_valid && apply, applied_freq == target_freq, "applied_freq differs from target_freq on apply")

    // Level never goes past failsafe
    `TFT_ASSERT_NOW(a_level_range, result_valid, level <= LVL_FAILSAFE, "level out of range")

    // No sample transfer in a configuration write cycle
    `TFT_ASSERT_NOW(a_cfg_blocks, cfg_wr_en, !temp_ready, "temp_ready high during configuration write")

    // A stalled result holds
    `TFT_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(target_freq) && $stable(applied_freq), "stalled result changed")

endmodule

bind thermal_freq_throttle_core tft_checker u_tft_checker (.*);

`default_nettype wire

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// Thermal frequency throttle - testbench
// Drives temperature samples over valid/ready with random gaps and result
// back-pressure, rewrites the limit registers between phases, and checks
// every result field against an in-bench prediction of the throttle levels,
// floor, ceiling and hysteresis.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import tft_pkg::*;

    // One result as the block reports it
    typedef struct packed {
        logic [FREQ_W-1:0]  target;
        logic               apply;
        logic [FREQ_W-1:0]  applied;
        logic [LEVEL_W-1:0] lvl;
    } limit_result_t;

    // One row of directed stimulus: a register write or a sample
    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [FREQ_W-1:0]    data;
        logic [TEMP_W-1:0]    temp;
        logic                 typed;
        limit_result_t        want;
    } stim_row_t;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int N_DIRECTED = 35;
    localparam int N_PHASES   = 12;
    localparam int PHASE_LEN  = 70;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FREQ_W-1:0]    cfg_data = '0;
    logic                 temp_valid = 1'b0;
    logic                 temp_ready;
    logic [TEMP_W-1:0]    temp_c = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic [FREQ_W-1:0]    target_freq;
    logic                 apply;
    logic [FREQ_W-1:0]    applied_freq;
    logic [LEVEL_W-1:0]   level;

    // Predictor copy of the registers and the applied limit
    logic [FREQ_W-1:0] cur_min = HW_MIN_RST;
    logic [FREQ_W-1:0] cur_max = HW_MAX_RST;
    logic [FREQ_W-1:0] cur_floor = '0;
    logic [FREQ_W-1:0] cur_ceiling = '0;
    logic [LIM_W-1:0]  cur_limit = LIM_RST;
    logic [FREQ_W-1:0] model_applied = '0;

    limit_result_t pending_limits [$];
    int            mismatch_cnt = 0;
    bit            steady = 1'b0;

    // Directed rows; reset settings give thresholds 75, 81, 88 and 95
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{1'b0, '0, '0, 9'd0,   1'b1, '{23'd3000000, 1'b1, 23'd3000000, LVL_COOL}},
        '{1'b0, '0, '0, 9'd75,  1'b1, '{23'd2670000, 1'b1, 23'd2670000, LVL_LIGHT}},
        '{1'b0, '0, '0, 9'd74,  1'b1, '{23'd3000000, 1'b1, 23'd3000000, LVL_COOL}},
        '{1'b0, '0, '0, 9'd81,  1'b1, '{23'd2230000, 1'b1, 23'd2230000, LVL_MEDIUM}},
        '{1'b0, '0, '0, 9'd88,  1'b1, '{23'd1680000, 1'b1, 23'd1680000, LVL_STRONG}},
        '{1'b0, '0, '0, 9'd95,  1'b1, '{23'd800000,  1'b1, 23'd800000,  LVL_FAILSAFE}},
        '{1'b0, '0, '0, 9'h0FF, 1'b1, '{23'd800000,  1'b0, 23'd800000,  LVL_FAILSAFE}},
        '{1'b0, '0, '0, 9'h100, 1'b1, '{23'd3000000, 1'b1, 23'd3000000, LVL_COOL}},
        '{1'b0, '0, '0, 9'h1FF, 1'b1, '{23'd3000000, 1'b0, 23'd3000000, LVL_COOL}},
        '{1'b0, '0, '0, 9'd87,  1'b1, '{23'd2230000, 1'b1, 23'd2230000, LVL_MEDIUM}},
        '{1'b0, '0, '0, 9'd80,  1'b1, '{23'd2670000, 1'b1, 23'd2670000, LVL_LIGHT}},
        '{1'b0, '0, '0, 9'd94,  1'b1, '{23'd1680000, 1'b1, 23'd1680000, LVL_STRONG}},
        '{1'b0, '0, '0, 9'd88,  1'b1, '{23'd1680000, 1'b0, 23'd1680000, LVL_STRONG}},
        // floor lifts a strong throttle but not failsafe
        '{1'b1, REG_SAFE_FLOOR, 23'd2500000, '0, 1'b0, '0},
        '{1'b0, '0, '0, 9'd90,  1'b0, '0},
        '{1'b0, '0, '0, 9'd100, 1'b0, '0},
        // ceiling below the minimum counts as unset; spare index does nothing
        '{1'b1, REG_SAFE_FLOOR,   23'd0,       '0, 1'b0, '0},
        '{1'b1, REG_SAFE_CEILING, 23'd500000,  '0, 1'b0, '0},
        '{1'b1, REG_SPARE,        23'h7FFFFF,  '0, 1'b0, '0},
        '{1'b0, '0, '0, 9'd10,  1'b0, '0},
        '{1'b1, REG_SAFE_CEILING, 23'd2000000, '0, 1'b0, '0},
        '{1'b0, '0, '0, 9'd0,   1'b0, '0},
        // minimum above maximum: negative range
        '{1'b1, REG_HW_MIN,       23'h7FFFFF,  '0, 1'b0, '0},
        '{1'b1, REG_HW_MAX,       23'd1,       '0, 1'b0, '0},
        '{1'b1, REG_SAFE_CEILING, 23'd0,       '0, 1'b0, '0},
        '{1'b0, '0, '0, 9'd85,  1'b0, '0},
        '{1'b0, '0, '0, 9'd50,  1'b0, '0},
        // zero limit: everything from zero degrees up is failsafe
        '{1'b1, REG_TEMP_LIMIT,   23'd0,       '0, 1'b0, '0},
        '{1'b0, '0, '0, 9'd0,   1'b0, '0},
        '{1'b0, '0, '0, 9'h1FF, 1'b0, '0},
        // widest range and highest limit
        '{1'b1, REG_TEMP_LIMIT,   23'd127,     '0, 1'b0, '0},
        '{1'b1, REG_HW_MIN,       23'd1,       '0, 1'b0, '0},
        '{1'b1, REG_HW_MAX,       23'h7FFFFF,  '0, 1'b0, '0},
        '{1'b0, '0, '0, 9'd126, 1'b0, '0},
        '{1'b0, '0, '0, 9'd100, 1'b0, '0}
    };

    thermal_freq_throttle_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .temp_valid   (temp_valid),
        .temp_ready   (temp_ready),
        .temp_c       (temp_c),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .target_freq  (target_freq),
        .apply        (apply),
        .applied_freq (applied_freq),
        .level        (level)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Compute the limit for one sample and advance the applied limit
    function automatic limit_result_t predict_throttle(input logic [TEMP_W-1:0] raw);
        longint        deg;
        longint        lo;
        longint        top;
        longint        lim;
        longint        span;
        longint        freq;
        longint        diff;
        limit_result_t r;
        deg = longint'($signed(raw));
        lo  = longint'(cur_min);
        top = longint'(cur_max);
        lim = longint'(cur_limit);
        if (cur_ceiling != '0 && cur_ceiling >= cur_min && cur_ceiling < cur_max)
        begin
            top = longint'(cur_ceiling);
        end
        span = top - lo;
        if (deg >= lim)
        begin
            freq  = lo;
            r.lvl = LVL_FAILSAFE;
        end
        else if (deg >= (lim * 93) / 100)
        begin
            freq  = lo + (span * 40) / 100;
            r.lvl = LVL_STRONG;
        end
        else if (deg >= (lim * 86) / 100)
        begin
            freq  = lo + (span * 65) / 100;
            r.lvl = LVL_MEDIUM;
        end
        else if (deg >= (lim * 79) / 100)
        begin
            freq  = lo + (span * 85) / 100;
            r.lvl = LVL_LIGHT;
        end
        else
        begin
            freq  = top;
            r.lvl = LVL_COOL;
        end
        // floor holds below the failsafe temperature only
        if (cur_floor != '0 && deg < lim && freq < longint'(cur_floor))
        begin
            freq = longint'(cur_floor);
        end
        diff = freq - longint'(model_applied);
        if (diff < 0)
        begin
            diff = -diff;
        end
        r.apply = (diff > span / 10);
        if (r.apply)
        begin
            model_applied = freq[FREQ_W-1:0];
        end
        r.target  = freq[FREQ_W-1:0];
        r.applied = model_applied;
        return r;
    endfunction

    function automatic logic [FREQ_W-1:0] wild_freq();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return FREQ_W'(1);
            2: return '1;
            default: return FREQ_W'($urandom);
        endcase
    endfunction

    // Present one sample, hold it until the transfer, then record the expectation
    task automatic send_sample(input logic [TEMP_W-1:0] raw, input bit typed,
                               input limit_result_t want);
        limit_result_t got;
        // idle about one cycle in four
        while (!steady && $urandom_range(0, 99) < 25)
        begin
            temp_valid <= 1'b0;
            @(posedge clk);
        end
        temp_c     <= raw;
        temp_valid <= 1'b1;
        @(posedge clk);
        while (!temp_ready) @(posedge clk);
        got = predict_throttle(raw);
        pending_limits.push_back(typed ? want : got);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain();
        temp_valid <= 1'b0;
        while (pending_limits.size() != 0) @(posedge clk);
    endtask

    // Write one register on the next edge; the caller closes the group
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [FREQ_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_HW_MIN:       cur_min = val;
            REG_HW_MAX:       cur_max = val;
            REG_SAFE_FLOOR:   cur_floor = val;
            REG_SAFE_CEILING: cur_ceiling = val;
            REG_TEMP_LIMIT:   cur_limit = val[LIM_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic cfg_done();
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Result back-pressure
    always @(posedge clk)
    begin
        result_ready <= steady || ($urandom_range(0, 99) >= 25);
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        limit_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_limits.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                begin
                    $display("unexpected result: target %0d level %0d", target_freq, level);
                end
            end
            else
            begin
                want = pending_limits.pop_front();
                if (target_freq !== want.target || apply !== want.apply ||
                    applied_freq !== want.applied || level !== want.lvl)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                    begin
                        $display("mismatch (exp/act): target %0d/%0d apply %0b/%0b",
                                 want.target, target_freq, want.apply, apply);
                        $display("                    applied %0d/%0d level %0d/%0d",
                                 want.applied, applied_freq, want.lvl, level);
                    end
                end
            end
        end
    end

    // Hard stop
    initial
    begin
        #5000000;
        $display("[thermal_freq_throttle_core] ERROR");
        $finish;
    end

    initial
    begin
        stim_row_t         row;
        bit                writing;
        bit                wild;
        logic [FREQ_W-1:0] mn;
        logic [FREQ_W-1:0] mx;
        logic [FREQ_W-1:0] fl;
        logic [FREQ_W-1:0] cl;
        logic [FREQ_W-1:0] lim_word;
        logic [TEMP_W-1:0] t;
        int                pick;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        writing = 1'b0;
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_cfg)
            begin
                if (!writing)
                begin
                    drain();
                    writing = 1'b1;
                end
                cfg_write(row.idx, row.data);
            end
            else
            begin
                if (writing)
                begin
                    cfg_done();
                    writing = 1'b0;
                end
                send_sample(row.temp, row.typed, row.want);
            end
        end

        // Random phases, each with fresh register settings
        t = '0;
        for (int p = 0; p < N_PHASES; p++)
        begin
            steady = (p == 3 || p == 4);
            wild   = (p == N_PHASES - 1) || (p != 0 && $urandom_range(0, 99) < 30);
            if (p == 0)
            begin
                mn = HW_MIN_RST;
                mx = HW_MAX_RST;
                fl = '0;
                cl = '0;
                lim_word = FREQ_W'(LIM_RST);
            end
            else if (wild)
            begin
                mn = wild_freq();
                mx = wild_freq();
                fl = wild_freq();
                cl = wild_freq();
                case ($urandom_range(0, 3))
                    0: lim_word = FREQ_W'(0);
                    1: lim_word = FREQ_W'(127);
                    2: lim_word = ($urandom_range(0, 1) != 0) ? FREQ_W'(50) : FREQ_W'(110);
                    default: lim_word = FREQ_W'($urandom_range(0, 127));
                endcase
                // upper data bits are outside the limit register
                lim_word[FREQ_W-1:LIM_W] = ($urandom_range(0, 1) != 0) ? '1 :
                                           (FREQ_W-LIM_W)'($urandom);
            end
            else
            begin
                mn = FREQ_W'($urandom_range(100000, 2000000));
                mx = FREQ_W'($urandom_range(int'(mn) + 200000, 8000000));
                fl = ($urandom_range(0, 1) != 0) ? '0 :
                     FREQ_W'($urandom_range(int'(mn), int'(mx)));
                cl = ($urandom_range(0, 1) != 0) ? '0 : FREQ_W'($urandom_range(1, 8000000));
                lim_word = FREQ_W'($urandom_range(50, 110));
            end
            drain();
            cfg_write(REG_HW_MIN, mn);
            cfg_write(REG_HW_MAX, mx);
            cfg_write(REG_SAFE_FLOOR, fl);
            cfg_write(REG_SAFE_CEILING, cl);
            cfg_write(REG_TEMP_LIMIT, lim_word);
            if (wild)
            begin
                cfg_write(REG_SPARE, FREQ_W'($urandom));
            end
            cfg_done();

            for (int k = 0; k < PHASE_LEN; k++)
            begin
                pick = $urandom_range(0, 99);
                // mostly around the thresholds, some small steps for hysteresis
                if (pick < 50)
                begin
                    t = TEMP_W'($urandom_range(0, int'(cur_limit) + 4));
                end
                else if (pick < 70)
                begin
                    t = t + TEMP_W'($urandom_range(0, 2)) - TEMP_W'(1);
                end
                else
                begin
                    t = TEMP_W'($urandom);
                end
                send_sample(t, 1'b0, '0);
            end
        end
        steady = 1'b0;

        // Let the pipeline empty, then settle
        drain();
        repeat (8) @(posedge clk);
        if (mismatch_cnt == 0)
        begin
            $display("[thermal_freq_throttle_core] OK");
        end
        else
        begin
            $display("[thermal_freq_throttle_core] ERROR");
        end
        $finish;
    end

endmodule
